// ----- hdl/chrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package chrt_pkg;

    // Fixed field widths of one word
    localparam int KEY_W    = 40;
    localparam int GRADE_W  = 14;
    localparam int STATUS_W = 3;
    localparam int DIGIT_W  = 4;

    // ASCII code of the digit zero; the hash adds it to every digit
    localparam int ASCII_ZERO = 48;

    // Default geometry
    localparam int DEF_BUCKETS      = 12;
    localparam int DEF_BUCKET_DEPTH = 4;
    localparam int DEF_KEY_DIGITS   = 10;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_SEARCH = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_FOUND   = 3'd1,
        ST_NOKEY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOGRADE = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
    } record_t;

endpackage

`default_nettype wire

// ----- hdl/chained_hash_record_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Record table of (key, grade) words kept in BUCKETS chains of up to BUCKET_DEPTH
// entries, keyed by a packed BCD number whose bucket is the sum of its digits'
// ASCII codes mod BUCKETS. Raise start with opcode, record_key and grade_value;
// the word is taken when busy is low, and busy stays high until the final
// result has been shown. Every result is on status/found_key/found_grade/last
// for exactly one cycle, marked by strobe, and the receiver must take it then:
// there is no way to hold results off. Insert, delete and lookup give one
// result; grade search gives one result per match (last on the final one) or a
// single "no grade match". The hash walks one digit per cycle through a
// shared adder; lookup and delete then read and compare the chain's entries
// in order, and a delete that finds its key moves each entry behind it down
// one place to close the gap. Grade search skips the hash and walks the slot
// memory through its single read port, bucket by bucket and each chain in
// order. The final result shows in the first cycle with busy low, and the
// next word can be taken at the edge that ends that cycle. The chain lengths
// clear at reset; the slot memory needs no clearing, as only entries below a
// chain's length are read.
module chained_hash_record_table_top #(
    parameter int BUCKETS      = chrt_pkg::DEF_BUCKETS,
    parameter int BUCKET_DEPTH = chrt_pkg::DEF_BUCKET_DEPTH,
    parameter int KEY_DIGITS   = chrt_pkg::DEF_KEY_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [chrt_pkg::KEY_W-1:0]    record_key,
    input  logic [chrt_pkg::GRADE_W-1:0]  grade_value,
    output logic                          strobe,
    output logic [chrt_pkg::STATUS_W-1:0] status,
    output logic [chrt_pkg::KEY_W-1:0]    found_key,
    output logic [chrt_pkg::GRADE_W-1:0]  found_grade,
    output logic                          last
);
    import chrt_pkg::*;

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int LW    = $clog2(BUCKET_DEPTH + 1);
    localparam int AW    = BW + DW;
    localparam int SLOTS = BUCKETS << DW;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - DIGIT_W * KEY_DIGITS);

    typedef enum logic [3:0] {
        S_IDLE,  // wait for a word
        S_HASH,  // digit-serial hash running
        S_DISP,  // bucket known, dispatch on opcode
        S_RD,    // read chain entry for key compare
        S_CMP,   // compare key of the entry just read
        S_DRD,   // delete: read the entry behind the gap
        S_DWR,   // delete: move it down one place
        S_SCAN,  // grade search: pick next slot or bucket
        S_SCMP,  // grade search: compare grade of the slot just read
        S_FIN    // grade search: flush the held match or report none
    } state_t;

    state_t           state_reg, state_next;
    opcode_t          op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [GRADE_W-1:0] grade_reg, grade_next;
    logic [BW-1:0]    bucket_reg, bucket_next;
    logic [LW-1:0]    idx_reg, idx_next;
    logic [LW-1:0]    chain_len_reg [BUCKETS];
    logic [LW-1:0]    chain_len_next [BUCKETS];
    logic             pend_valid_reg, pend_valid_next;
    record_t          pend_reg, pend_next;

    logic             strobe_reg, strobe_next;
    status_t          status_reg, status_next;
    logic [KEY_W-1:0] fkey_reg, fkey_next;
    logic [GRADE_W-1:0] fgrade_reg, fgrade_next;
    logic             last_reg, last_next;

    logic             hash_start;
    logic             hash_done;
    logic [BW-1:0]    hash_bucket;
    logic [KEY_W-1:0] key_in;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    record_t          mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    record_t          mem_rdata;

    logic [LW-1:0]    cur_len;
    logic [LW:0]      len_w;
    logic [LW:0]      idx_p1;
    logic [LW:0]      idx_p2;

    assign key_in = record_key & KEY_MASK;

    chrt_hash #(
        .BUCKETS    (BUCKETS),
        .KEY_DIGITS (KEY_DIGITS),
        .BW         (BW)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key_in),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    chrt_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        cur_len = chain_len_reg[bucket_reg];
        len_w   = {1'b0, cur_len};
        idx_p1  = {1'b0, idx_reg} + (LW+1)'(1);
        idx_p2  = idx_p1 + (LW+1)'(1);

        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        grade_next      = grade_reg;
        bucket_next     = bucket_reg;
        idx_next        = idx_reg;
        chain_len_next  = chain_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        // results show for one cycle only
        strobe_next = 1'b0;
        status_next = status_reg;
        fkey_next   = fkey_reg;
        fgrade_next = fgrade_reg;
        last_next   = last_reg;

        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {bucket_reg, idx_reg[DW-1:0]};
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = {bucket_reg, idx_reg[DW-1:0]};

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next    = opcode_t'(opcode);
                    key_next   = key_in;
                    grade_next = grade_value;
                    idx_next   = '0;
                    if (opcode_t'(opcode) == OP_SEARCH) begin
                        bucket_next     = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end else begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH: begin
                if (hash_done) begin
                    bucket_next = hash_bucket;
                    state_next  = S_DISP;
                end
            end

            S_DISP: begin
                fkey_next   = key_reg;
                fgrade_next = '0;
                last_next   = 1'b1;
                if (op_reg == OP_INSERT) begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                    if (cur_len >= LW'(BUCKET_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        // append at the chain tail
                        mem_we         = 1'b1;
                        mem_waddr      = {bucket_reg, cur_len[DW-1:0]};
                        mem_wdata.key  = key_reg;
                        mem_wdata.grade = grade_reg;
                        chain_len_next[bucket_reg] = idx_p1[LW-1:0] + cur_len;
                        status_next    = ST_DONE;
                    end
                end else if (cur_len == '0) begin
                    strobe_next = 1'b1;
                    status_next = ST_NOKEY;
                    state_next  = S_IDLE;
                end else begin
                    state_next = S_RD;
                end
            end

            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_CMP;
            end

            S_CMP: begin
                fkey_next   = key_reg;
                fgrade_next = '0;
                last_next   = 1'b1;
                if (mem_rdata.key == key_reg) begin
                    if (op_reg == OP_LOOKUP) begin
                        strobe_next = 1'b1;
                        status_next = ST_FOUND;
                        fgrade_next = mem_rdata.grade;
                        state_next  = S_IDLE;
                    end else if (idx_p1 < len_w) begin
                        state_next = S_DRD;
                    end else begin
                        // match was the tail: just shorten the chain
                        chain_len_next[bucket_reg] = cur_len - LW'(1);
                        strobe_next = 1'b1;
                        status_next = ST_DONE;
                        state_next  = S_IDLE;
                    end
                end else if (idx_p1 >= len_w) begin
                    strobe_next = 1'b1;
                    status_next = ST_NOKEY;
                    state_next  = S_IDLE;
                end else begin
                    idx_next   = idx_p1[LW-1:0];
                    state_next = S_RD;
                end
            end

            S_DRD: begin
                mem_re     = 1'b1;
                mem_raddr  = {bucket_reg, idx_p1[DW-1:0]};
                state_next = S_DWR;
            end

            S_DWR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = idx_p1[LW-1:0];
                if (idx_p2 < len_w) begin
                    state_next = S_DRD;
                end else begin
                    chain_len_next[bucket_reg] = cur_len - LW'(1);
                    strobe_next = 1'b1;
                    status_next = ST_DONE;
                    fkey_next   = key_reg;
                    fgrade_next = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_SCAN: begin
                if (idx_reg < cur_len) begin
                    mem_re     = 1'b1;
                    state_next = S_SCMP;
                end else if (bucket_reg == BW'(BUCKETS - 1)) begin
                    state_next = S_FIN;
                end else begin
                    bucket_next = bucket_reg + BW'(1);
                    idx_next    = '0;
                end
            end

            S_SCMP: begin
                if (mem_rdata.grade == grade_reg) begin
                    // emit the held match now that another one follows it
                    if (pend_valid_reg) begin
                        strobe_next = 1'b1;
                        status_next = ST_FOUND;
                        fkey_next   = pend_reg.key;
                        fgrade_next = pend_reg.grade;
                        last_next   = 1'b0;
                    end
                    pend_next       = mem_rdata;
                    pend_valid_next = 1'b1;
                end
                idx_next   = idx_p1[LW-1:0];
                state_next = S_SCAN;
            end

            S_FIN: begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_valid_reg) begin
                    status_next = ST_FOUND;
                    fkey_next   = pend_reg.key;
                    fgrade_next = pend_reg.grade;
                end else begin
                    status_next = ST_NOGRADE;
                    fkey_next   = key_reg;
                    fgrade_next = '0;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            grade_reg      <= '0;
            bucket_reg     <= '0;
            idx_reg        <= '0;
            for (int b = 0; b < BUCKETS; b++) begin
                chain_len_reg[b] <= '0;
            end
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            strobe_reg     <= 1'b0;
            status_reg     <= ST_DONE;
            fkey_reg       <= '0;
            fgrade_reg     <= '0;
            last_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            grade_reg      <= grade_next;
            bucket_reg     <= bucket_next;
            idx_reg        <= idx_next;
            chain_len_reg  <= chain_len_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            strobe_reg     <= strobe_next;
            status_reg     <= status_next;
            fkey_reg       <= fkey_next;
            fgrade_reg     <= fgrade_next;
            last_reg       <= last_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign found_key   = fkey_reg;
    assign found_grade = fgrade_reg;
    assign last        = last_reg;

    // final result of a word always comes with the block ready again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> state_reg == S_IDLE)
        else $error("final result shown while still busy");

    // a non-final result only comes out of a grade search that keeps running
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> state_reg == S_SCAN && op_reg == OP_SEARCH)
        else $error("non-final result outside grade search");

    // hash completion only lands while the sequencer waits for it
    a_hash_sync: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash done outside hash wait");

    // a chain never grows past its depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len <= LW'(BUCKET_DEPTH))
        else $error("chain length above depth");

    // a held search match is flushed before the block goes idle
    a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("search match left unreported");

endmodule

`default_nettype wire

// ----- hdl/chrt_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Digit-serial bucket hash: one BCD digit per cycle, running residue mod BUCKETS.
module chrt_hash #(
    parameter int BUCKETS    = chrt_pkg::DEF_BUCKETS,
    parameter int KEY_DIGITS = chrt_pkg::DEF_KEY_DIGITS,
    parameter int BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [chrt_pkg::KEY_W-1:0] key,
    output logic                       done,
    output logic [BW-1:0]              bucket
);
    import chrt_pkg::*;

    localparam int CW = $clog2(KEY_DIGITS + 1);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [BW-1:0]    acc_reg, acc_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    // (48 + digit) mod BUCKETS for every nibble value
    logic [BW-1:0] dig_res [16];
    logic [BW:0]   sum_wide;
    logic [BW:0]   sum_red;

    for (genvar g = 0; g < 16; g++) begin : g_res
        assign dig_res[g] = BW'((ASCII_ZERO + g) % BUCKETS);
    end

    always_comb begin
        sum_wide  = {1'b0, acc_reg} + {1'b0, dig_res[key_reg[DIGIT_W-1:0]]};
        sum_red   = sum_wide - (BW+1)'(BUCKETS);
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            key_next = key;
            cnt_next = CW'(KEY_DIGITS);
            acc_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            // one compare-subtract keeps the residue below BUCKETS
            acc_next = (sum_wide >= (BW+1)'(BUCKETS)) ? sum_red[BW-1:0] : sum_wide[BW-1:0];
            key_next = key_reg >> DIGIT_W;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_reg  <= '0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            key_reg  <= key_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign bucket = acc_reg;

endmodule

`default_nettype wire

// ----- hdl/chrt_slot_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slot store: one write port, one read port, registered read data.
module chrt_slot_ram #(
    parameter int DEPTH = chrt_pkg::DEF_BUCKETS * chrt_pkg::DEF_BUCKET_DEPTH,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  chrt_pkg::record_t wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output chrt_pkg::record_t rdata
);
    import chrt_pkg::*;

    record_t mem [DEPTH];
    record_t rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import chrt_pkg::*;

    localparam int SLOT_COUNT = DEF_BUCKETS * DEF_BUCKET_DEPTH;
    localparam int RANDOM_WORDS = 410;
    // Idle time after the last reply: comfortably longer than the longest grade
    // search, which walks every slot, so the block can go quiet at the end.
    localparam int DRAIN_CYCLES = 160;

    // One command word, plus the idle cycles the sender waits before offering it
    typedef struct {
        opcode_t          op;
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
        int unsigned        gap;
    } table_cmd_t;

    // One result word as the block should show it
    typedef struct {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] grade;
        logic               last;
    } table_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           opcode = OP_INSERT;
    logic [KEY_W-1:0]     record_key = '0;
    logic [GRADE_W-1:0]   grade_value = '0;
    logic                 strobe;
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     found_key;
    logic [GRADE_W-1:0]   found_grade;
    logic                 last;

    // Words waiting to be offered, and replies the table should still produce
    table_cmd_t   pending_words[$];
    table_reply_t expected_replies[$];
    table_cmd_t   offered_word;
    int unsigned  gap_left;
    int unsigned  words_taken;
    int unsigned  words_total;
    int unsigned  mismatch_count;

    // Shadow copy of the record table
    logic [KEY_W-1:0]   shadow_key[SLOT_COUNT];
    logic [GRADE_W-1:0] shadow_grade[SLOT_COUNT];
    int unsigned        shadow_len[DEF_BUCKETS];

    // Stimulus bookkeeping: recent keys and grades feed later deletes,
    // lookups and searches, so that most of them hit stored entries.
    logic [KEY_W-1:0]   recent_keys[$];
    logic [GRADE_W-1:0] recent_grades[$];
    int unsigned        idle_mode;

    chained_hash_record_table_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .record_key  (record_key),
        .grade_value (grade_value),
        .strobe      (strobe),
        .status      (status),
        .found_key   (found_key),
        .found_grade (found_grade),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bucket of a key: sum of the ASCII codes of its ten digits, mod the bucket count.
    // Nibbles above nine still enter the sum as 48 plus the nibble.
    function automatic int unsigned bucket_of_key(input logic [KEY_W-1:0] key);
        int unsigned sum;
        sum = 0;
        for (int d = 0; d < DEF_KEY_DIGITS; d++)
        begin
            sum += ASCII_ZERO + int'(key[DIGIT_W*d +: DIGIT_W]);
        end
        return sum % DEF_BUCKETS;
    endfunction

    function automatic void push_reply(input status_t st, input logic [KEY_W-1:0] key,
                                       input logic [GRADE_W-1:0] grade, input logic fin);
        table_reply_t r;
        r.status = st;
        r.key    = key;
        r.grade  = grade;
        r.last   = fin;
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Apply one accepted word to the shadow table and queue the replies it causes
    function automatic void apply_to_table(input table_cmd_t w);
        int unsigned b;
        int unsigned base;
        int unsigned len;
        int unsigned hits;
        int          pos;
        b    = bucket_of_key(w.key);
        base = b * DEF_BUCKET_DEPTH;
        len  = shadow_len[b];
        pos  = -1;
        hits = 0;
        case (w.op) inside
            OP_INSERT:
            begin
                if (len >= DEF_BUCKET_DEPTH)
                begin
                    push_reply(ST_FULL, w.key, '0, 1'b1);
                end
                else
                begin
                    shadow_key[base + len]   = w.key;
                    shadow_grade[base + len] = w.grade;
                    shadow_len[b]            = len + 1;
                    push_reply(ST_DONE, w.key, '0, 1'b1);
                end
            end
            OP_DELETE, OP_LOOKUP:
            begin
                // first match in the chain wins
                for (int i = 0; i < len; i++)
                begin
                    if (pos < 0 && shadow_key[base + i] == w.key)
                    begin
                        pos = i;
                    end
                end
                if (pos < 0)
                begin
                    push_reply(ST_NOKEY, w.key, '0, 1'b1);
                end
                else if (w.op == OP_LOOKUP)
                begin
                    push_reply(ST_FOUND, w.key, shadow_grade[base + pos], 1'b1);
                end
                else
                begin
                    // close the gap behind the removed entry
                    for (int j = pos; j + 1 < len; j++)
                    begin
                        shadow_key[base + j]   = shadow_key[base + j + 1];
                        shadow_grade[base + j] = shadow_grade[base + j + 1];
                    end
                    shadow_len[b] = len - 1;
                    push_reply(ST_DONE, w.key, '0, 1'b1);
                end
            end
            default:
            begin
                // grade search: buckets in order, each chain in order
                for (int bb = 0; bb < DEF_BUCKETS; bb++)
                begin
                    for (int i = 0; i < shadow_len[bb]; i++)
                    begin
                        if (shadow_grade[bb * DEF_BUCKET_DEPTH + i] == w.grade)
                        begin
                            push_reply(ST_FOUND, shadow_key[bb * DEF_BUCKET_DEPTH + i],
                                       w.grade, 1'b0);
                            hits++;
                        end
                    end
                end
                if (hits == 0)
                begin
                    push_reply(ST_NOGRADE, w.key, '0, 1'b1);
                end
                else
                begin
                    expected_replies[expected_replies.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    // Queue a command word; its lead gap follows the current idle mode
    function automatic void add_word(input opcode_t op, input logic [KEY_W-1:0] key,
                                     input logic [GRADE_W-1:0] grade);
        table_cmd_t w;
        w.op    = op;
        w.key   = key;
        w.grade = grade;
        case (idle_mode)
            0: w.gap = 0;
            1: w.gap = $urandom_range(0, 14);
            default: w.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14)
                                                         : $urandom_range(0, 2);
        endcase
        pending_words.insert(pending_words.size(), w);
        if (op == OP_INSERT)
        begin
            recent_keys.insert(recent_keys.size(), key);
            recent_grades.insert(recent_grades.size(), grade);
            if (recent_keys.size() > 24)
            begin
                void'(recent_keys.pop_front());
                void'(recent_grades.pop_front());
            end
        end
    endfunction

    // Fresh key: mostly decimal digits, some sparse, a few with non-decimal
    // nibbles and a few drawn from all 40 bits
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        sel = $urandom_range(0, 99);
        k   = '0;
        if (sel < 6)
        begin
            k[39:32] = 8'($urandom());
            k[31:0]  = $urandom();
        end
        else if (sel < 30)
        begin
            k[DIGIT_W * $urandom_range(0, 9) +: DIGIT_W] = 4'($urandom_range(0, 9));
            k[DIGIT_W * $urandom_range(0, 9) +: DIGIT_W] = 4'($urandom_range(0, 9));
        end
        else
        begin
            for (int d = 0; d < DEF_KEY_DIGITS; d++)
            begin
                if (sel < 40 && $urandom_range(0, 4) == 0)
                    k[DIGIT_W*d +: DIGIT_W] = 4'($urandom_range(10, 15));
                else
                    k[DIGIT_W*d +: DIGIT_W] = 4'($urandom_range(0, 9));
            end
        end
        return k;
    endfunction

    // Grades cluster on a few values so searches find several matches
    function automatic logic [GRADE_W-1:0] draw_grade();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            case ($urandom_range(0, 5))
                0: return 14'd0;
                1: return 14'd10000;
                2: return 14'd5000;
                3: return 14'd7550;
                4: return 14'd9999;
                default: return 14'd1;
            endcase
        end
        else if (sel < 95)
        begin
            return 14'($urandom_range(0, 10000));
        end
        return 14'($urandom_range(0, 16383));
    endfunction

    // Driver: offer the oldest pending word, keep start high until busy drops,
    // and hold off for the word's lead gap before raising start again.
    always @(posedge clk or negedge rst_n)
    begin
        logic       line_free;
        table_cmd_t nw;
        if (!rst_n)
        begin
            start       <= 1'b0;
            opcode      <= OP_INSERT;
            record_key  <= '0;
            grade_value <= '0;
            gap_left    <= 0;
            words_taken <= 0;
        end
        else
        begin
            line_free = !start || !busy;
            if (start && !busy)
            begin
                apply_to_table(offered_word);
                words_taken <= words_taken + 1;
            end
            if (line_free)
            begin
                if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    nw = pending_words.pop_front();
                    offered_word <= nw;
                    start        <= 1'b1;
                    opcode       <= nw.op;
                    record_key   <= nw.key;
                    grade_value  <= nw.grade;
                    gap_left     <= (pending_words.size() > 0) ? pending_words[0].gap : 0;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed word must match the oldest expected reply
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && strobe)
        begin
            if (expected_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status=%0d key=%h grade=%0d last=%b",
                             status, found_key, found_grade, last);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status || found_key !== want.key ||
                    found_grade !== want.grade || last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected status=%0d key=%h grade=%0d last=%b,",
                                  " got status=%0d key=%h grade=%0d last=%b"},
                                 want.status, want.key, want.grade, want.last,
                                 status, found_key, found_grade, last);
                end
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        mismatch_count = 0;
        idle_mode      = 1;
        // The chain lengths clear at reset; slots are never read unwritten.
        for (int b = 0; b < DEF_BUCKETS; b++)
            shadow_len[b] = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            shadow_key[s]   = '0;
            shadow_grade[s] = '0;
        end

        // Directed part: empty table, a full chain, duplicates, gap closing,
        // non-decimal nibbles and out-of-range grades.
        add_word(OP_LOOKUP, 40'h00_0000_0000, 14'd0);
        add_word(OP_SEARCH, 40'h00_0000_0000, 14'd0);
        add_word(OP_DELETE, 40'h99_9999_9999, 14'd0);
        // same digit sum, so all five land in one bucket; the fifth finds it full
        add_word(OP_INSERT, 40'h00_0000_0001, 14'd0);
        add_word(OP_INSERT, 40'h00_0000_0010, 14'd10000);
        add_word(OP_INSERT, 40'h00_0000_0100, 14'd9999);
        add_word(OP_INSERT, 40'h00_0000_1000, 14'd10000);
        add_word(OP_INSERT, 40'h00_0001_0000, 14'd1);
        add_word(OP_LOOKUP, 40'h00_0000_0100, 14'd0);
        add_word(OP_SEARCH, 40'h00_0000_0000, 14'd10000);
        add_word(OP_DELETE, 40'h00_0000_0001, 14'd0);
        add_word(OP_LOOKUP, 40'h00_0001_0000, 14'd0);
        add_word(OP_INSERT, 40'h00_0001_0000, 14'd1);
        add_word(OP_INSERT, 40'h00_0000_0010, 14'd5);
        add_word(OP_DELETE, 40'h00_0000_1000, 14'd0);
        add_word(OP_INSERT, 40'h00_0000_0010, 14'd5);
        add_word(OP_LOOKUP, 40'h00_0000_0010, 14'd0);
        add_word(OP_DELETE, 40'h00_0000_0010, 14'd0);
        add_word(OP_LOOKUP, 40'h00_0000_0010, 14'd0);
        add_word(OP_INSERT, 40'h99_9999_9999, 14'd16383);
        add_word(OP_INSERT, 40'hFF_FFFF_FFFF, 14'd10000);
        add_word(OP_LOOKUP, 40'hFF_FFFF_FFFF, 14'd0);
        add_word(OP_SEARCH, 40'hFF_FFFF_FFFF, 14'd16383);
        add_word(OP_SEARCH, 40'h12_3456_7890, 14'd10000);
        add_word(OP_INSERT, 40'h12_3456_7890, 14'h2AAA);

        // Random part: inserts mixed with deletes and lookups of recent keys, and
        // searches for recent grades; the rest is fresh keys that mostly miss.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 30 == 0)
                idle_mode = $urandom_range(0, 2);
            sel = $urandom_range(0, 99);
            if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0)
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else
                k = fresh_key();
            if (sel < 35)
                add_word(OP_INSERT, ($urandom_range(0, 2) == 0) ? k : fresh_key(),
                         draw_grade());
            else if (sel < 55)
                add_word(OP_DELETE, k, draw_grade());
            else if (sel < 83)
                add_word(OP_LOOKUP, k, draw_grade());
            else if (recent_grades.size() > 0 && $urandom_range(0, 9) < 7)
                add_word(OP_SEARCH, fresh_key(),
                         recent_grades[$urandom_range(0, recent_grades.size() - 1)]);
            else
                add_word(OP_SEARCH, fresh_key(), draw_grade());
        end
        words_total = pending_words.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every reply to come back, then let
        // the block sit idle long enough to expose any stray result.
        while (words_taken < words_total || expected_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("chained_hash_record_table_top verification clean");
        else
            $display("chained_hash_record_table_top verification failed");
        $finish;
    end

    // Hard stop: the slowest correct run takes well under a millisecond
    initial
    begin
        #5000000;
        $display("chained_hash_record_table_top verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/chrt_pkg.sv
hdl/chrt_hash.sv
hdl/chrt_slot_ram.sv
hdl/chained_hash_record_table_top.sv
dv/testbench.sv
